/* rtl/fsg_pkg.sv */
// Falling sand grid step: shared field widths, codes and the window type.
// No dependencies; imported by every module of the block.
package fsg_pkg;

  localparam int KIND_W     = 2;
  localparam int OFS_W      = 6;
  localparam int RIDX_W     = 6;
  localparam int IN_DATA_W  = 16;
  localparam int ROW_W      = 64;
  localparam int LEFT_W     = 6;
  localparam int RIGHT_W    = 7;
  localparam int TOP_W      = 6;
  localparam int COL_W      = 6;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  localparam logic [KIND_W-1:0] KIND_TICK = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_LEFT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP   = 2'd2;

  localparam logic [RIGHT_W-1:0] RIGHT_RESET = 7'd64;

  // Column bounds of the active window; right is already clamped to the grid.
  typedef struct packed {
    logic [LEFT_W-1:0]  left;
    logic [RIGHT_W-1:0] right;
  } win_t;

endpackage

/* rtl/fsg_cell_unit.sv */
// Shared single-cell update: moves one sand grain of the current row into
// the row below (down, down-left, down-right). Uses fsg_pkg.
module fsg_cell_unit #(
  parameter int COLS = 64
) (
  input  logic [COLS-1:0]           cur_row,
  input  logic [COLS-1:0]           below_row,
  input  logic [fsg_pkg::COL_W-1:0] col,
  input  fsg_pkg::win_t             win,
  output logic [COLS-1:0]           cur_row_next,
  output logic [COLS-1:0]           below_row_next
);
  import fsg_pkg::*;

  localparam int CW = $clog2(COLS);

  logic [CW-1:0]    idx, idx_l, idx_r;
  logic [COL_W-1:0] col_m;
  logic [COL_W:0]   col_p;
  logic             has_l, has_r;

  always_comb begin
    col_m = col - COL_W'(1);
    col_p = {1'b0, col} + (COL_W+1)'(1);
    idx   = col[CW-1:0];
    idx_l = col_m[CW-1:0];
    idx_r = col_p[CW-1:0];
    has_l = col > win.left;
    has_r = col_p < win.right;
    cur_row_next   = cur_row;
    below_row_next = below_row;
    if (cur_row[idx]) begin
      if (!below_row[idx]) begin
        below_row_next[idx] = 1'b1;
        cur_row_next[idx]   = 1'b0;
      end else if (has_l && !below_row[idx_l]) begin
        below_row_next[idx_l] = 1'b1;
        cur_row_next[idx]     = 1'b0;
      end else if (has_r && !below_row[idx_r]) begin
        below_row_next[idx_r] = 1'b1;
        cur_row_next[idx]     = 1'b0;
      end
    end
  end

endmodule

/* rtl/fsg_drop_mask.sv */
// Column mask of a dropped sand block, clipped to the window.
// Uses fsg_pkg.
module fsg_drop_mask #(
  parameter int COLS  = 64,
  parameter int BLOCK = 5
) (
  input  fsg_pkg::win_t             win,
  input  logic [fsg_pkg::OFS_W-1:0] offset,
  output logic [COLS-1:0]           mask
);
  import fsg_pkg::*;

  localparam int HALF = BLOCK / 2;

  logic signed [8:0] lo, hi;

  always_comb begin
    lo = $signed({3'b000, win.left}) + $signed({3'b000, offset}) - $signed(9'(HALF));
    hi = lo + $signed(9'(BLOCK));
    for (int c = 0; c < COLS; c++) begin
      mask[c] = ($signed(9'(c)) >= lo) && ($signed(9'(c)) < hi) &&
                (7'(c) >= {1'b0, win.left}) && (7'(c) < win.right);
    end
  end

endmodule

/* rtl/falling_sand_grid_step_core.sv */
// Falling sand grid step, top level: row memory, sequencer and stream ports.
// Uses fsg_pkg, fsg_cell_unit and fsg_drop_mask.
//
// Input beats on s_axis: tuser carries the kind (tick, drop, read), tdata
// the drop offset and the row index. Every input beat gives exactly one
// output beat on m_axis: the stored row for a read, zero otherwise.
// Window registers are written on the cfg channel (always ready), index 0
// left, 1 right, 2 top; write them only while the block is idle.
// One item at a time; s_axis_tready is high only when the sequencer idles.
// A tick visits one cell per cycle through the shared cell unit, window row
// by window row from the bottom up. A drop reads and rewrites each block row
// inside the grid, and a read fetches the addressed row; an empty window, a
// one-row tick and the unused kind 3 go straight to the result state.
// s_axis_tready comes back at the same edge that loads the result.
// The output register holds a finished beat while m_axis_tready is low;
// the next item is accepted meanwhile, but its result waits for the slot.
// After reset the grid is cleared one row per cycle before the first input
// beat is taken; cfg writes are taken throughout.
module falling_sand_grid_step_core #(
  parameter int ROWS  = 64,
  parameter int COLS  = 64,
  parameter int BLOCK = 5
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // [5:0] drop_offset, [11:6] row_index, [15:12] zero
  input  logic [fsg_pkg::IN_DATA_W-1:0]      s_axis_tdata,
  // [1:0] kind
  input  logic [fsg_pkg::KIND_W-1:0]         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // [63:0] row_bits
  output logic [fsg_pkg::ROW_W-1:0]          m_axis_tdata,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [fsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [fsg_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import fsg_pkg::*;

  localparam int RA  = $clog2(ROWS);
  localparam int RCW = ((RA > 7) ? RA : 7) + 1;
  localparam int BCW = $clog2(BLOCK + 1);

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_TBOT, S_TBOTLD, S_TRD, S_TLD, S_TSCAN, S_TWB, S_TFIN,
    S_DRD, S_DWR, S_RRD, S_RESULT
  } state_t;

  state_t state;

  logic [LEFT_W-1:0]  window_left;
  logic [RIGHT_W-1:0] window_right;
  logic [TOP_W-1:0]   window_top;

  logic [RCW-1:0]   row;
  logic [COL_W-1:0] col;
  logic [BCW-1:0]   cnt;
  logic [OFS_W-1:0] offset;
  logic             res_row;
  logic [COLS-1:0]  cur, below;

  logic [COLS-1:0] mem [ROWS];
  logic [COLS-1:0] mem_q;
  logic            mem_we, mem_re;
  logic [RA-1:0]   mem_wa, mem_ra;
  logic [COLS-1:0] mem_wd;

  win_t            win;
  logic [RCW-1:0]  top_ext, row_p;
  logic            win_empty, col_last;
  logic [COLS-1:0] cur_next, below_next, mask;

  logic [OFS_W-1:0]  in_offset;
  logic [RIDX_W-1:0] in_row;

  assign in_offset = s_axis_tdata[OFS_W-1:0];
  assign in_row    = s_axis_tdata[OFS_W+RIDX_W-1:OFS_W];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == S_IDLE);

  always_comb begin
    win.left  = window_left;
    win.right = (window_right > RIGHT_W'(COLS)) ? RIGHT_W'(COLS) : window_right;
    top_ext   = RCW'(window_top);
    win_empty = ({1'b0, window_left} >= win.right) || (top_ext >= RCW'(ROWS));
    row_p     = row + RCW'(1);
    col_last  = row[0] ? (col == window_left)
                       : ({1'b0, col} == win.right - RIGHT_W'(1));
  end

  fsg_cell_unit #(.COLS(COLS)) u_cell (
    .cur_row        (cur),
    .below_row      (below),
    .col            (col),
    .win            (win),
    .cur_row_next   (cur_next),
    .below_row_next (below_next)
  );

  fsg_drop_mask #(.COLS(COLS), .BLOCK(BLOCK)) u_mask (
    .win    (win),
    .offset (offset),
    .mask   (mask)
  );

  always_comb begin
    mem_we = 1'b0;
    mem_re = 1'b0;
    mem_wa = row[RA-1:0];
    mem_ra = row[RA-1:0];
    mem_wd = '0;
    case (state)
      S_CLEAR: mem_we = 1'b1;
      S_TBOT: begin
        mem_re = 1'b1;
        mem_ra = RA'(ROWS - 1);
      end
      S_TRD, S_DRD, S_RRD: mem_re = 1'b1;
      S_TWB: begin
        mem_we = 1'b1;
        mem_wa = row_p[RA-1:0];
        mem_wd = below;
      end
      S_TFIN: begin
        mem_we = 1'b1;
        mem_wd = below;
      end
      S_DWR: begin
        mem_we = 1'b1;
        mem_wd = mem_q | mask;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    if (mem_re) mem_q <= mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window_left  <= '0;
      window_right <= RIGHT_RESET;
      window_top   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_LEFT:  window_left  <= cfg_data[LEFT_W-1:0];
        CFG_RIGHT: window_right <= cfg_data[RIGHT_W-1:0];
        CFG_TOP:   window_top   <= cfg_data[TOP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      row           <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && state != S_RESULT) m_axis_tvalid <= 1'b0;
      case (state)
        S_CLEAR: begin
          row <= row_p;
          if (row == RCW'(ROWS - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (s_axis_tvalid) begin
            offset  <= in_offset;
            case (s_axis_tuser)
              KIND_TICK: begin
                res_row <= 1'b0;
                if (win_empty || top_ext >= RCW'(ROWS - 1)) state <= S_RESULT;
                else state <= S_TBOT;
              end
              KIND_DROP: begin
                res_row <= 1'b0;
                row   <= top_ext;
                cnt   <= BCW'(BLOCK);
                state <= win_empty ? S_RESULT : S_DRD;
              end
              KIND_READ: begin
                row <= RCW'(in_row);
                if (RCW'(in_row) < RCW'(ROWS)) begin
                  res_row <= 1'b1;
                  state   <= S_RRD;
                end else begin
                  res_row <= 1'b0;
                  state   <= S_RESULT;
                end
              end
              default: begin
                res_row <= 1'b0;
                state   <= S_RESULT;
              end
            endcase
          end
        end
        S_TBOT: state <= S_TBOTLD;
        S_TBOTLD: begin
          below <= mem_q;
          row   <= RCW'(ROWS - 2);
          state <= S_TRD;
        end
        S_TRD: state <= S_TLD;
        S_TLD: begin
          cur   <= mem_q;
          col   <= row[0] ? COL_W'(win.right - RIGHT_W'(1)) : window_left;
          state <= S_TSCAN;
        end
        S_TSCAN: begin
          cur   <= cur_next;
          below <= below_next;
          col   <= row[0] ? col - COL_W'(1) : col + COL_W'(1);
          if (col_last) state <= S_TWB;
        end
        S_TWB: begin
          below <= cur;
          if (row == top_ext) begin
            state <= S_TFIN;
          end else begin
            row   <= row - RCW'(1);
            state <= S_TRD;
          end
        end
        S_TFIN: state <= S_RESULT;
        S_DRD: begin
          if (cnt == '0 || row >= RCW'(ROWS)) state <= S_RESULT;
          else state <= S_DWR;
        end
        S_DWR: begin
          row   <= row_p;
          cnt   <= cnt - BCW'(1);
          state <= S_DRD;
        end
        S_RRD: state <= S_RESULT;
        S_RESULT: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= res_row ? ROW_W'(mem_q) : '0;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* verif/tb_falling_sand_grid_step_core.sv */
// Testbench for falling_sand_grid_step_core: random and directed tick, drop and read beats
// checked against a shadow grid kept in a scoreboard class. Window set through the cfg channel.
// Depends on fsg_pkg and the core RTL only.
module tb_falling_sand_grid_step_core;
  timeunit 1ns;
  timeprecision 1ps;
  import fsg_pkg::*;

  localparam int GRID_ROWS = 64;
  localparam int GRID_COLS = 64;
  localparam int BLOCK_W   = 5;
  localparam int PHASES    = 8;
  localparam int PHASE_ITEMS = 12;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  class sand_grid_shadow;
    logic [ROW_W-1:0] cells [GRID_ROWS];
    int win_left, win_right, win_top;
    logic [ROW_W-1:0] rows_due [$];
    int errors;

    function new();
      foreach (cells[r]) cells[r] = '0;
      win_left  = 0;
      win_right = RIGHT_RESET;
      win_top   = 0;
      errors    = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        CFG_LEFT: win_left = val[LEFT_W-1:0];
        CFG_RIGHT: win_right = val[RIGHT_W-1:0];
        CFG_TOP: win_top = val[TOP_W-1:0];
        default: ;
      endcase
    endfunction

    function int right_edge();
      return (win_right > GRID_COLS) ? GRID_COLS : win_right;
    endfunction

    function void settle_tick();
      int hi, c;
      hi = right_edge();
      if (hi <= win_left || win_top >= GRID_ROWS) return;
      for (int r = GRID_ROWS - 1; r >= win_top; r--) begin
        for (int k = 0; k < hi - win_left; k++) begin
          c = ((r % 2) == 1) ? hi - 1 - k : win_left + k;
          if (cells[r][c] && r + 1 < GRID_ROWS) begin
            if (!cells[r+1][c]) begin
              cells[r+1][c] = 1'b1;
              cells[r][c]   = 1'b0;
            end else if (c - 1 >= win_left && !cells[r+1][c-1]) begin
              cells[r+1][c-1] = 1'b1;
              cells[r][c]     = 1'b0;
            end else if (c + 1 < hi && !cells[r+1][c+1]) begin
              cells[r+1][c+1] = 1'b1;
              cells[r][c]     = 1'b0;
            end
          end
        end
      end
    endfunction

    function void pour_block(int ofs);
      int hi, first;
      hi = right_edge();
      first = win_left + ofs - BLOCK_W / 2;
      for (int dr = 0; dr < BLOCK_W && win_top + dr < GRID_ROWS; dr++) begin
        for (int dc = 0; dc < BLOCK_W; dc++) begin
          if (first + dc >= win_left && first + dc < hi) cells[win_top+dr][first+dc] = 1'b1;
        end
      end
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [OFS_W-1:0] ofs,
                            logic [RIDX_W-1:0] ridx);
      logic [ROW_W-1:0] row;
      row = '0;
      case (kind)
        KIND_TICK: settle_tick();
        KIND_DROP: pour_block(int'(ofs));
        KIND_READ: if (ridx < GRID_ROWS) row = cells[ridx];
        default: ;
      endcase
      rows_due.push_back(row);
    endfunction

    function void check_row(logic [ROW_W-1:0] got);
      logic [ROW_W-1:0] want;
      if (rows_due.size() == 0) begin
        $error("row_bits: expected no beat, actual %h", got);
        errors++;
        return;
      end
      want = rows_due.pop_front();
      if (got !== want) begin
        $error("row_bits: expected %h, actual %h", want, got);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_DATA_W-1:0] s_axis_tdata = '0;
  logic [KIND_W-1:0] s_axis_tuser = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [ROW_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int src_idle_pct = 0;
  int sink_stall_pct = 0;
  int hold_left = 0;

  sand_grid_shadow grid_shadow = new();

  falling_sand_grid_step_core #(
    .ROWS(GRID_ROWS),
    .COLS(GRID_COLS),
    .BLOCK(BLOCK_W)
  ) u_dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #40_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Output side: check each beat, then stall at random or hold off for a counted stretch.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) grid_shadow.check_row(m_axis_tdata);
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  task automatic offer_item(input logic [KIND_W-1:0] kind, input logic [OFS_W-1:0] ofs,
                            input logic [RIDX_W-1:0] ridx);
    if (src_idle_pct > 0 && $urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {{(IN_DATA_W-OFS_W-RIDX_W){1'b0}}, ridx, ofs};
    do @(posedge clk); while (!s_axis_tready);
    grid_shadow.note_item(kind, ofs, ridx);
  endtask

  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (grid_shadow.rows_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_window(input int left, input int right, input int top);
    logic [CFG_IDX_W-1:0] idx [3];
    logic [CFG_DATA_W-1:0] val [3];
    idx = '{CFG_LEFT, CFG_RIGHT, CFG_TOP};
    val = '{CFG_DATA_W'(left), CFG_DATA_W'(right), CFG_DATA_W'(top)};
    for (int i = 0; i < 3; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[i];
      cfg_data  <= val[i];
      do @(posedge clk); while (!cfg_ready);
      grid_shadow.write_reg(idx[i], val[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Mostly drop, settle, read back; otherwise one beat of any kind with random fields.
  task automatic random_burst(output int n);
    int span, ticks, reads;
    logic [KIND_W-1:0] kind;
    n = 0;
    span = grid_shadow.right_edge() - grid_shadow.win_left + 1;
    if (span < 1) span = 1;
    if (span > 63) span = 63;
    if ($urandom_range(99) < 75) begin
      offer_item(KIND_DROP, OFS_W'($urandom_range(0, span)), RIDX_W'($urandom()));
      ticks = $urandom_range(1, 4);
      reads = $urandom_range(1, 3);
      repeat (ticks) offer_item(KIND_TICK, OFS_W'($urandom()), RIDX_W'($urandom()));
      repeat (reads) begin
        offer_item(KIND_READ, OFS_W'($urandom()),
                   RIDX_W'($urandom_range(grid_shadow.win_top, GRID_ROWS - 1)));
      end
      n = 1 + ticks + reads;
    end else begin
      kind = KIND_W'($urandom_range(0, 3));
      offer_item(kind, OFS_W'($urandom()), RIDX_W'($urandom()));
      n = (kind != KIND_SPARE);
    end
  endtask

  initial begin
    int ph_left [PHASES] = '{8, 0, 30, 0, 50, 20, 17, 63};
    int ph_right [PHASES] = '{24, 127, 40, 1, 64, 12, 100, 64};
    int ph_top [PHASES] = '{40, 0, 52, 48, 56, 30, 44, 0};
    int done, n;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // full grid: empty reads, clipped drops at both edges, full-grid ticks, unused kind
    set_window(0, 64, 0);
    offer_item(KIND_READ, 6'd63, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd63);
    offer_item(KIND_SPARE, 6'd63, 6'd63);
    offer_item(KIND_DROP, 6'd0, 6'd0);
    offer_item(KIND_DROP, 6'd63, 6'd0);
    offer_item(KIND_DROP, 6'd31, 6'd63);
    offer_item(KIND_READ, 6'd0, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd4);
    offer_item(KIND_READ, 6'd0, 6'd5);
    offer_item(KIND_TICK, 6'd63, 6'd63);
    offer_item(KIND_TICK, 6'd0, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd4);
    offer_item(KIND_READ, 6'd0, 6'd6);
    offer_item(KIND_READ, 6'd0, 6'd63);
    offer_item(KIND_SPARE, 6'd0, 6'd0);
    wait_quiet();

    // right edge past the grid, one column wide
    set_window(63, 127, 60);
    offer_item(KIND_DROP, 6'd0, 6'd0);
    offer_item(KIND_DROP, 6'd63, 6'd0);
    offer_item(KIND_TICK, 6'd0, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd60);
    offer_item(KIND_READ, 6'd0, 6'd63);
    wait_quiet();

    // empty window: nothing may change
    set_window(40, 10, 0);
    offer_item(KIND_DROP, 6'd20, 6'd0);
    offer_item(KIND_TICK, 6'd0, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd0);
    wait_quiet();

    // single bottom row window
    set_window(0, 1, 63);
    offer_item(KIND_DROP, 6'd0, 6'd0);
    offer_item(KIND_TICK, 6'd0, 6'd0);
    offer_item(KIND_READ, 6'd0, 6'd63);
    wait_quiet();

    for (int p = 0; p < PHASES; p++) begin
      set_window(ph_left[p], ph_right[p], ph_top[p]);
      case (p % 4)
        0: begin
          src_idle_pct = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct = 60;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct = 0;
          sink_stall_pct = 60;
        end
        default: begin
          src_idle_pct = 9;
          sink_stall_pct = 9;
        end
      endcase
      done = 0;
      if (p == 2) begin
        // long output hold-off while reads keep coming, so the input backs up
        hold_left = 300;
        repeat (10) begin
          offer_item(KIND_READ, OFS_W'($urandom()), RIDX_W'($urandom()));
          done++;
        end
      end
      while (done < PHASE_ITEMS) begin
        random_burst(n);
        done += n;
      end
      wait_quiet();
    end

    src_idle_pct = 0;
    sink_stall_pct = 0;
    wait_quiet();
    if (grid_shadow.errors == 0 && grid_shadow.rows_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

/* falling_sand_grid_step_core.f */
rtl/fsg_pkg.sv
rtl/fsg_cell_unit.sv
rtl/fsg_drop_mask.sv
rtl/falling_sand_grid_step_core.sv
verif/tb_falling_sand_grid_step_core.sv
